// File: rtl/pss_pkg.sv
// shared types and constants for the positional sequence store
`default_nettype none

package pss_pkg;

	localparam int unsigned DATA_W = 32;
	// positions and counts fit in 7 bits, which bounds the capacity at 127
	localparam int unsigned POS_W  = 7;

	typedef enum logic [2:0] {
		OP_ADD_FRONT = 3'd0,
		OP_ADD_BACK  = 3'd1,
		OP_INSERT_AT = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_AT    = 3'd5,
		OP_READ_FWD  = 3'd6,
		OP_READ_BWD  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD    = 3'd0,
		CELL_INSERT  = 3'd1,
		CELL_DELETE  = 3'd2,
		CELL_ROT_FWD = 3'd3,
		CELL_ROT_BWD = 3'd4
	} cell_op_t;

	// broadcast to every cell of the chain each cycle
	typedef struct packed {
		cell_op_t          op;
		logic [POS_W-1:0]  index;
		logic [POS_W-1:0]  count;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

`default_nettype wire

// File: rtl/pss_cell.sv
// one chain cell: holds, loads a value, shifts from a neighbor or wraps head/tail
`default_nettype none

module pss_cell #(
	parameter int unsigned INDEX = 0
) (
	input  wire logic                        clk,
	input  wire pss_pkg::cell_cmd_t          cmd,
	input  wire logic [pss_pkg::DATA_W-1:0]  left_data,
	input  wire logic [pss_pkg::DATA_W-1:0]  right_data,
	input  wire logic [pss_pkg::DATA_W-1:0]  head_data,
	input  wire logic [pss_pkg::DATA_W-1:0]  tail_data,
	output logic      [pss_pkg::DATA_W-1:0]  data
);

	localparam logic [pss_pkg::POS_W-1:0] IDX = pss_pkg::POS_W'(INDEX);

	logic [pss_pkg::DATA_W-1:0] data_q;
	logic [pss_pkg::DATA_W-1:0] data_next;
	logic [pss_pkg::POS_W-1:0]  idx_plus1;

	assign idx_plus1 = IDX + pss_pkg::POS_W'(1);

	always_comb begin
		data_next = data_q;
		unique case (cmd.op)
			pss_pkg::CELL_INSERT: begin
				if (IDX == cmd.index) begin
					data_next = cmd.value;
				end else if (IDX > cmd.index) begin
					data_next = left_data;
				end
			end
			pss_pkg::CELL_DELETE: begin
				if (IDX >= cmd.index && idx_plus1 < cmd.count) begin
					data_next = right_data;
				end
			end
			pss_pkg::CELL_ROT_FWD: begin
				// the front element wraps to the back of the filled range
				if (idx_plus1 < cmd.count) begin
					data_next = right_data;
				end else if (idx_plus1 == cmd.count) begin
					data_next = head_data;
				end
			end
			pss_pkg::CELL_ROT_BWD: begin
				if (IDX == '0) begin
					data_next = tail_data;
				end else if (IDX < cmd.count) begin
					data_next = left_data;
				end
			end
			default: begin
				data_next = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_next;
	end

	assign data = data_q;

endmodule

`default_nettype wire

// File: rtl/positional_sequence_store.sv
// top level of the positional sequence store: control, cell chain and result register
//
// An ordered store of up to CAPACITY signed 32-bit values held in a chain of cells.
// The command channel (cmd_valid/cmd_stall) carries operation, position and value;
// the result channel (res_valid/res_stall) carries status, element, element_count
// and last. A transaction is taken on a clock edge with valid high and stall low.
// Add, insert and delete act at acceptance: every cell compares its index with the
// position and shifts from a neighbor, loads the value or holds. Their single
// result appears in the result register the cycle after acceptance.
// A read of n elements gives n results, one per cycle while the receiver keeps
// res_stall low; the chain rotates by one place per result and is back in order
// after the last one. A read of an empty store gives one result.
// The block takes one command at a time: cmd_stall is high while a read is
// still producing results, and while a result is held by res_stall.
// A non-read command can be followed by another in the next cycle while res_stall
// is low; a read holds off the next command until its last result is given.
// Reset empties the store and drops any pending result; cell contents are
// not cleared.
`default_nettype none

module positional_sequence_store #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic        [2:0]  operation,
	input  wire logic        [7:0]  position,
	input  wire logic signed [31:0] value,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic             [1:0]  status,
	output logic signed      [31:0] element,
	output logic             [6:0]  element_count,
	output logic                    last
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned DW    = pss_pkg::DATA_W;
	localparam int unsigned PW    = pss_pkg::POS_W;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             busy_q;
	logic             rd_bwd_q;
	logic [CNT_W-1:0] rd_left_q;

	logic                res_valid_q;
	pss_pkg::status_t    status_q;
	logic [DW-1:0]       element_q;
	logic [6:0]          element_count_q;
	logic                last_q;

	logic out_free;
	logic cmd_fire;
	logic emit;
	logic full;
	logic empty;
	logic ins_pos_ok;
	logic del_pos_ok;
	logic [8:0] pos9;
	logic [8:0] cnt9;

	pss_pkg::op_t       op;
	pss_pkg::status_t   cmd_status;
	pss_pkg::cell_cmd_t cell_cmd;
	logic               start_read;

	logic [DW-1:0] cell_data [CAPACITY];
	logic [DW-1:0] head_data;
	logic [DW-1:0] tail_data;

	assign out_free  = !res_valid_q || !res_stall;
	assign cmd_stall = busy_q || !out_free;
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign emit      = busy_q && out_free;

	assign op    = pss_pkg::op_t'(operation);
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);
	assign pos9  = {1'b0, position};
	assign cnt9  = 9'(count_q);
	assign ins_pos_ok = (position != 8'd0) && (pos9 <= cnt9 + 9'd1);
	assign del_pos_ok = (position != 8'd0) && (pos9 <= cnt9);

	// tail of the filled range, picked by one-hot compare
	always_comb begin
		tail_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (count_q == CNT_W'(i + 1)) begin
				tail_data = tail_data | cell_data[i];
			end
		end
	end
	assign head_data = cell_data[0];

	// command decode
	always_comb begin
		cell_cmd       = '0;
		cell_cmd.op    = pss_pkg::CELL_HOLD;
		cell_cmd.count = PW'(count_q);
		cell_cmd.value = value;
		cmd_status     = pss_pkg::ST_OK;
		count_next     = count_q;
		start_read     = 1'b0;
		if (cmd_fire) begin
			unique case (op)
				pss_pkg::OP_ADD_FRONT, pss_pkg::OP_ADD_BACK: begin
					if (full) begin
						cmd_status = pss_pkg::ST_FULL;
					end else begin
						cell_cmd.op    = pss_pkg::CELL_INSERT;
						cell_cmd.index = (op == pss_pkg::OP_ADD_FRONT) ? '0 : PW'(count_q);
						count_next     = count_q + CNT_W'(1);
					end
				end
				pss_pkg::OP_INSERT_AT: begin
					if (!ins_pos_ok) begin
						cmd_status = pss_pkg::ST_BADPOS;
					end else if (full) begin
						cmd_status = pss_pkg::ST_FULL;
					end else begin
						cell_cmd.op    = pss_pkg::CELL_INSERT;
						cell_cmd.index = PW'(position - 8'd1);
						count_next     = count_q + CNT_W'(1);
					end
				end
				pss_pkg::OP_DEL_FRONT, pss_pkg::OP_DEL_BACK: begin
					if (empty) begin
						cmd_status = pss_pkg::ST_EMPTY;
					end else begin
						cell_cmd.op    = pss_pkg::CELL_DELETE;
						cell_cmd.index = (op == pss_pkg::OP_DEL_FRONT) ? '0 :
							PW'(count_q - CNT_W'(1));
						count_next     = count_q - CNT_W'(1);
					end
				end
				pss_pkg::OP_DEL_AT: begin
					if (empty) begin
						cmd_status = pss_pkg::ST_EMPTY;
					end else if (!del_pos_ok) begin
						cmd_status = pss_pkg::ST_BADPOS;
					end else begin
						cell_cmd.op    = pss_pkg::CELL_DELETE;
						cell_cmd.index = PW'(position - 8'd1);
						count_next     = count_q - CNT_W'(1);
					end
				end
				default: begin
					// read forward or backward
					if (empty) begin
						cmd_status = pss_pkg::ST_EMPTY;
					end else begin
						start_read = 1'b1;
					end
				end
			endcase
		end else if (emit) begin
			cell_cmd.op = rd_bwd_q ? pss_pkg::CELL_ROT_BWD : pss_pkg::CELL_ROT_FWD;
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DW-1:0] left_d;
		logic [DW-1:0] right_d;
		if (g == 0) begin : g_first
			assign left_d = cell_data[0];
		end else begin : g_left
			assign left_d = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_final
			assign right_d = cell_data[g];
		end else begin : g_right
			assign right_d = cell_data[g+1];
		end
		pss_cell #(
			.INDEX(g)
		) u_cell (
			.clk        (clk),
			.cmd        (cell_cmd),
			.left_data  (left_d),
			.right_data (right_d),
			.head_data  (head_data),
			.tail_data  (tail_data),
			.data       (cell_data[g])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			rd_bwd_q    <= 1'b0;
			rd_left_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (start_read) begin
				busy_q    <= 1'b1;
				rd_bwd_q  <= (op == pss_pkg::OP_READ_BWD);
				rd_left_q <= count_q;
			end else if (emit) begin
				rd_left_q <= rd_left_q - CNT_W'(1);
				if (rd_left_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
			if ((cmd_fire && !start_read) || emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q        <= pss_pkg::ST_OK;
			element_q       <= rd_bwd_q ? tail_data : head_data;
			element_count_q <= 7'(count_q);
			last_q          <= (rd_left_q == CNT_W'(1));
		end else if (cmd_fire && !start_read) begin
			status_q        <= cmd_status;
			element_q       <= '0;
			element_count_q <= 7'(count_next);
			last_q          <= 1'b1;
		end
	end

	assign res_valid     = res_valid_q;
	assign status        = status_q;
	assign element       = element_q;
	assign element_count = element_count_q;
	assign last          = last_q;

	// a read in progress always has elements left to give
	a_busy_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rd_left_q != '0 && count_q != '0))
		else $error("read in progress with nothing left");

	// the fill count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	// the final read result ends the read and is marked last
	a_read_end: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && rd_left_q == CNT_W'(1)) |=> (!busy_q && res_valid_q && last_q))
		else $error("read did not end on its final result");

	// the store does not change size while a read is in progress
	a_read_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> $stable(count_q))
		else $error("count changed during a read");

endmodule

`default_nettype wire
